// File: hw/rtl/skak_pkg.sv
// Shared types, constants and helpers of the spherical k-means assign/accumulate block.
`default_nettype none
package skak_pkg;

  localparam int VAL_W  = 16;
  localparam int ACC_W  = 40;
  localparam int PROD_W = 32;
  localparam int COL_W  = 12;
  localparam int CL_W   = 4;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // command codes
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SIM  = 2'd1,
    CMD_ACC  = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  // result kinds
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_SUM = 1'b1;

  // classified item passed from front to back
  typedef struct packed {
    cmd_t                    cmd;
    logic [COL_W-1:0]        column;
    logic [CL_W-1:0]         cluster;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    prev_none;
    logic [CL_W-1:0]         prev;
    logic                    wr_center;  // in-range center load
    logic                    mac;        // similarity term to add
    logic                    acc;        // in-range accumulate
    logic                    rd_ok;      // in-range readout
    logic                    emit;       // item yields a result
  } item_t;

  // one result item
  typedef struct packed {
    logic                    kind;
    logic [CL_W-1:0]         best;
    logic                    moved;
    logic signed [ACC_W-1:0] sim;
    logic signed [ACC_W-1:0] sum;
  } result_t;

  // clamp a one-bit-grown sum to the 40-bit signed range
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
    logic signed [ACC_W-1:0] r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/skak_fifo.sv
// Small register FIFO used for the item queue and the result queue.
`default_nettype none
module skak_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   pop,
  output logic [WIDTH-1:0]            rdata,
  output logic                        empty,
  output logic                        full,
  output logic [$clog2(DEPTH):0]      count
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  assign empty = (count == '0);
  assign full  = (count == (AW+1)'(DEPTH));
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/skak_front.sv
// Front end: accepts input items and classifies them for the back end.
`default_nettype none
module skak_front #(
  parameter int NUM_CLUSTERS = 16,
  parameter int NUM_COLUMNS  = 4096
) (
  input  wire logic [1:0]                      command,
  input  wire logic [11:0]                     column,
  input  wire logic [3:0]                      cluster,
  input  wire logic signed [15:0]              value,
  input  wire logic                            last_of_row,
  input  wire logic                            element_present,
  input  wire logic signed [4:0]               previous_cluster,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [$clog2(NUM_CLUSTERS+1)-1:0] nact,
  input  wire logic                            enable,
  input  wire logic                            q_full,
  output logic                                 push,
  output skak_pkg::item_t                      item
);
  logic col_ok;
  logic cl_ok;
  logic cl_act;
  skak_pkg::cmd_t cmd;

  assign in_ready = enable && !q_full;
  assign push     = in_valid && in_ready;

  // range checks
  assign col_ok = (17'(column) < 17'(NUM_COLUMNS));
  assign cl_ok  = (8'(cluster) < 8'(NUM_CLUSTERS));
  assign cl_act = (8'(cluster) < 8'(nact));
  assign cmd    = skak_pkg::cmd_t'(command);

  // decode
  always_comb begin
    item           = '0;
    item.cmd       = cmd;
    item.column    = column;
    item.cluster   = cluster;
    item.value     = value;
    item.last      = last_of_row;
    item.prev_none = previous_cluster[4];
    item.prev      = previous_cluster[3:0];
    unique case (cmd)
      skak_pkg::CMD_LOAD: item.wr_center = col_ok && cl_ok;
      skak_pkg::CMD_SIM: begin
        item.mac  = element_present && col_ok;
        item.emit = last_of_row;
      end
      skak_pkg::CMD_ACC:  item.acc = element_present && col_ok && cl_act;
      skak_pkg::CMD_READ: begin
        item.rd_ok = col_ok && cl_ok;
        item.emit  = 1'b1;
      end
      default: item = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/skak_argmax.sv
// Registered comparison tree picking the best cluster, with result formatting.
`default_nettype none
module skak_argmax #(
  parameter int N = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic signed [39:0]       vals [N],
  input  wire logic [N-1:0]             lane_ok,
  input  wire logic                     kind,
  input  wire logic signed [39:0]       sum,
  input  wire logic                     prev_none,
  input  wire logic [3:0]               prev,
  output logic                          out_valid,
  output skak_pkg::result_t             result
);
  localparam int L  = $clog2(N);
  localparam int P  = 1 << L;
  localparam int IW = (L < 1) ? 1 : L;

  logic signed [39:0] tv [L+1][P];
  logic               tk [L+1][P];
  logic [IW-1:0]      ti [L+1][P];
  logic               sv [L+1];
  logic               skind [L+1];
  logic signed [39:0] ssum [L+1];
  logic               spn [L+1];
  logic [3:0]         sprev [L+1];

  // leaves
  always_ff @(posedge clk) begin
    for (int j = 0; j < P; j++) begin
      tv[0][j] <= (j < N) ? vals[j] : '0;
      tk[0][j] <= (j < N) ? lane_ok[j] : 1'b0;
      ti[0][j] <= IW'(j);
    end
    skind[0] <= kind;
    ssum[0]  <= sum;
    spn[0]   <= prev_none;
    sprev[0] <= prev;
  end

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else     sv[0] <= in_valid;
  end

  // tree levels; left wins ties, so the lower index is kept
  for (genvar l = 0; l < L; l++) begin : g_lvl
    always_ff @(posedge clk) begin
      for (int j = 0; j < P; j++) begin
        if (j < (P >> (l + 1))) begin
          if (tk[l][2*j+1] && (!tk[l][2*j] || (tv[l][2*j+1] > tv[l][2*j]))) begin
            tv[l+1][j] <= tv[l][2*j+1];
            ti[l+1][j] <= ti[l][2*j+1];
          end else begin
            tv[l+1][j] <= tv[l][2*j];
            ti[l+1][j] <= ti[l][2*j];
          end
          tk[l+1][j] <= tk[l][2*j] || tk[l][2*j+1];
        end else begin
          tv[l+1][j] <= '0;
          ti[l+1][j] <= '0;
          tk[l+1][j] <= 1'b0;
        end
      end
      skind[l+1] <= skind[l];
      ssum[l+1]  <= ssum[l];
      spn[l+1]   <= spn[l];
      sprev[l+1] <= sprev[l];
    end

    always_ff @(posedge clk) begin
      if (rst) sv[l+1] <= 1'b0;
      else     sv[l+1] <= sv[l];
    end
  end

  // format the result at the root
  assign out_valid = sv[L];
  always_comb begin
    result = '0;
    result.kind = skind[L];
    if (skind[L] == skak_pkg::KIND_SUM) begin
      result.sum = ssum[L];
    end else begin
      result.best  = skak_pkg::CL_W'(ti[L][0]);
      result.moved = spn[L] || (8'(sprev[L]) != 8'(ti[L][0]));
      result.sim   = tv[L][0];
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/skak_back.sv
// Back end: center store, similarity MACs, new-center sums and row selection.
`default_nettype none
module skak_back #(
  parameter int NUM_CLUSTERS = 16,
  parameter int NUM_COLUMNS  = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              issue,
  input  wire skak_pkg::item_t                   item,
  input  wire logic [$clog2(NUM_CLUSTERS+1)-1:0] nact,
  output logic                                   clr_busy,
  output logic                                   res_valid,
  output skak_pkg::result_t                      result
);
  localparam int NC     = NUM_CLUSTERS;
  localparam int NW     = $clog2(NC + 1);
  localparam int CW     = $clog2(NC);
  localparam int COLW   = $clog2(NUM_COLUMNS);
  // sum address is {column, cluster}, so each column owns a power-of-two slot
  localparam int SDEPTH = NUM_COLUMNS << CW;
  localparam int SAW    = CW + COLW;

  logic [NC*16-1:0]   cmem [NUM_COLUMNS];
  logic signed [39:0] smem [SDEPTH];

  logic [COLW-1:0] col_idx;
  logic [CW-1:0]   cl_idx;
  logic [SAW-1:0]  s0_addr;

  logic [SAW-1:0]  clr_addr;

  logic               s1_valid;
  skak_pkg::item_t    s1_item;
  logic [SAW-1:0]     s1_addr;
  logic [NC*16-1:0]   cword;
  logic signed [39:0] s_rd;
  logic               fwd_hit;
  logic signed [39:0] fwd_data;
  logic signed [39:0] cur;
  logic               s1_we;
  logic signed [39:0] s1_wdata;
  logic signed [39:0] s1_sum;

  logic               s2_valid;
  skak_pkg::item_t    s2_item;
  logic signed [39:0] s2_sum;
  logic signed [31:0] prod [NC];
  logic signed [39:0] rowsim [NC];
  logic signed [39:0] newsum [NC];
  logic [NC-1:0]      lane_ok;

  assign col_idx = COLW'(item.column);
  assign cl_idx  = CW'(item.cluster);
  assign s0_addr = {col_idx, cl_idx};

  // center store: one wide word per column, one lane per cluster
  always_ff @(posedge clk) begin
    if (issue && item.wr_center) begin
      for (int k = 0; k < NC; k++) begin
        if (cl_idx == CW'(k)) cmem[col_idx][k*16 +: 16] <= item.value;
      end
    end
    cword <= cmem[col_idx];
  end

  // clearing pass over the sum memory after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SAW'(SDEPTH - 1)) clr_busy <= 1'b0;
    end
  end

  // sum memory read with forwarding from the write in flight
  always_ff @(posedge clk) begin
    s_rd     <= smem[s0_addr];
    fwd_hit  <= s1_we && (s1_addr == s0_addr);
    fwd_data <= s1_wdata;
  end

  always_ff @(posedge clk) begin
    if (clr_busy)   smem[clr_addr] <= '0;
    else if (s1_we) smem[s1_addr]  <= s1_wdata;
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= issue;
    s1_item <= item;
    s1_addr <= s0_addr;
  end

  // accumulate or read-and-clear
  always_comb begin
    cur      = fwd_hit ? fwd_data : s_rd;
    s1_we    = s1_valid && (s1_item.acc || s1_item.rd_ok);
    s1_wdata = s1_item.acc ? skak_pkg::sat_acc(41'(cur) + 41'(s1_item.value)) : '0;
    s1_sum   = s1_item.rd_ok ? cur : '0;
  end

  // lane multipliers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      prod[k] <= s1_item.value * $signed(cword[k*16 +: 16]);
    end
    s2_item <= s1_item;
    s2_sum  <= s1_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  // per-cluster similarity accumulation
  always_comb begin
    for (int k = 0; k < NC; k++) begin
      lane_ok[k] = (NW'(k) < nact);
      newsum[k]  = (s2_item.mac && lane_ok[k]) ?
                   skak_pkg::sat_acc(41'(rowsim[k]) + 41'(prod[k])) : rowsim[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NC; k++) rowsim[k] <= '0;
    end else if (s2_valid && (s2_item.cmd == skak_pkg::CMD_SIM)) begin
      for (int k = 0; k < NC; k++) rowsim[k] <= s2_item.last ? '0 : newsum[k];
    end
  end

  skak_argmax #(.N(NC)) u_argmax (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid && s2_item.emit),
    .vals      (newsum),
    .lane_ok   (lane_ok),
    .kind      ((s2_item.cmd == skak_pkg::CMD_READ) ? skak_pkg::KIND_SUM
                                                     : skak_pkg::KIND_ROW),
    .sum       (s2_sum),
    .prev_none (s2_item.prev_none),
    .prev      (s2_item.prev),
    .out_valid (res_valid),
    .result    (result)
  );
endmodule
`default_nettype wire

// File: hw/rtl/spherical_kmeans_assign_accumulate.sv
// Top level of the spherical k-means assign/accumulate block.
// Takes one item per clock while in_ready is high: center loads, row nonzeros
// (multiplied against every in-use center lane of one wide center word in
// parallel), new-center accumulates and sum readouts. Results leave in item order;
// a row result or a readout passes the item queue, the stage-1 registers, the
// multiplier registers and the registered argmax tree. Queues on both sides let
// input and output stall independently. After reset the new-center sum memory is
// swept to zero, all NUM_COLUMNS times NUM_CLUSTERS rounded up to a power of two
// entries (65536 by default), while in_ready stays low; configuration writes are
// accepted throughout.
`default_nettype none
module spherical_kmeans_assign_accumulate #(
  parameter int NUM_CLUSTERS = 16,
  parameter int NUM_COLUMNS  = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         command,
  input  wire logic [11:0]        column,
  input  wire logic [3:0]         cluster,
  input  wire logic signed [15:0] value,
  input  wire logic               last_of_row,
  input  wire logic               element_present,
  input  wire logic signed [4:0]  previous_cluster,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    result_kind,
  output logic [3:0]              best_cluster,
  output logic                    moved,
  output logic signed [39:0]      best_similarity,
  output logic signed [39:0]      sum_value
);
  localparam int NW        = $clog2(NUM_CLUSTERS + 1);
  localparam int L         = $clog2(NUM_CLUSTERS);
  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 1 << $clog2(L + 6);
  localparam int OAW       = $clog2(OUT_DEPTH);
  localparam int IW_BITS   = $bits(skak_pkg::item_t);
  localparam int RW_BITS   = $bits(skak_pkg::result_t);

  logic [4:0]    clusters_in_use;
  logic [7:0]    eff;
  logic [NW-1:0] nact;

  logic                    clr_busy;
  logic                    push;
  skak_pkg::item_t         f_item;
  logic [IW_BITS-1:0]      q_rdata;
  logic                    q_empty;
  logic                    q_full;
  logic [$clog2(Q_DEPTH):0] q_count;
  logic                    issue;
  skak_pkg::item_t         b_item;

  logic                    res_valid;
  skak_pkg::result_t       res;
  logic [RW_BITS-1:0]      o_rdata;
  skak_pkg::result_t       o_res;
  logic                    o_empty;
  logic                    o_full;
  logic [OAW:0]            o_count;
  logic [OAW:0]            pend;
  logic                    credit_ok;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) clusters_in_use <= 5'd16;
    else if (cfg_valid && cfg_ready) clusters_in_use <= cfg_data;
  end

  // effective cluster count
  always_comb begin
    if (clusters_in_use == 5'd0) eff = 8'd1;
    else if (8'(clusters_in_use) > 8'(NUM_CLUSTERS)) eff = 8'(NUM_CLUSTERS);
    else eff = 8'(clusters_in_use);
  end
  assign nact = eff[NW-1:0];

  skak_front #(.NUM_CLUSTERS(NUM_CLUSTERS), .NUM_COLUMNS(NUM_COLUMNS)) u_front (
    .command          (command),
    .column           (column),
    .cluster          (cluster),
    .value            (value),
    .last_of_row      (last_of_row),
    .element_present  (element_present),
    .previous_cluster (previous_cluster),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .nact             (nact),
    .enable           (!clr_busy),
    .q_full           (q_full),
    .push             (push),
    .item             (f_item)
  );

  skak_fifo #(.WIDTH(IW_BITS), .DEPTH(Q_DEPTH)) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_item),
    .pop   (issue),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full),
    .count (q_count)
  );

  // issue only with room reserved for every result still in flight
  assign credit_ok = ((OAW+2)'(pend) + (OAW+2)'(o_count)) < (OAW+2)'(OUT_DEPTH);
  assign issue     = !q_empty && credit_ok && (q_count != '0);
  assign b_item    = skak_pkg::item_t'(q_rdata);

  always_ff @(posedge clk) begin
    if (rst) pend <= '0;
    else pend <= pend + (OAW+1)'(issue && b_item.emit) - (OAW+1)'(res_valid);
  end

  skak_back #(.NUM_CLUSTERS(NUM_CLUSTERS), .NUM_COLUMNS(NUM_COLUMNS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .item      (b_item),
    .nact      (nact),
    .clr_busy  (clr_busy),
    .res_valid (res_valid),
    .result    (res)
  );

  skak_fifo #(.WIDTH(RW_BITS), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_valid && !o_full),
    .wdata (res),
    .pop   (out_valid && out_ready),
    .rdata (o_rdata),
    .empty (o_empty),
    .full  (o_full),
    .count (o_count)
  );

  // result outputs
  assign o_res           = skak_pkg::result_t'(o_rdata);
  assign out_valid       = !o_empty;
  assign result_kind     = o_res.kind;
  assign best_cluster    = o_res.best;
  assign moved           = o_res.moved;
  assign best_similarity = o_res.sim;
  assign sum_value       = o_res.sum;
endmodule
`default_nettype wire

// File: sim/tb_spherical_kmeans_assign_accumulate.sv
// Testbench for the spherical k-means assign/accumulate block: directed table plus random items.
`timescale 1ns / 1ps
module tb_spherical_kmeans_assign_accumulate;

  typedef struct {
    skak_pkg::cmd_t     cmd;
    logic [11:0]        col;
    logic [3:0]         cl;
    logic signed [15:0] val;
    logic               last;
    logic               pres;
    logic signed [4:0]  prev;
  } item_s;

  typedef struct {
    item_s             it;
    bit                typed;   // expected result written in below
    skak_pkg::result_t res;
  } row_s;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [11:0] column = '0;
  logic [3:0] cluster = '0;
  logic signed [15:0] value = '0;
  logic last_of_row = 1'b0;
  logic element_present = 1'b0;
  logic signed [4:0] previous_cluster = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic result_kind;
  logic [3:0] best_cluster;
  logic moved;
  logic signed [39:0] best_similarity;
  logic signed [39:0] sum_value;

  spherical_kmeans_assign_accumulate dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .column(column), .cluster(cluster), .value(value),
    .last_of_row(last_of_row), .element_present(element_present),
    .previous_cluster(previous_cluster),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .best_cluster(best_cluster), .moved(moved),
    .best_similarity(best_similarity), .sum_value(sum_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  localparam longint SIM_MAX = 64'sd549755813887;
  localparam longint SIM_MIN = -64'sd549755813888;

  // mirrored block state
  logic signed [15:0] center_mem [0:65535];
  longint             sum_mem [0:65535];
  longint             row_sim [0:15];
  logic [4:0]         clusters_reg;
  int                 center_cols[$];   // columns with all 16 centers loaded

  skak_pkg::result_t expected_q[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  function automatic longint clamp40(longint v);
    if (v > SIM_MAX) return SIM_MAX;
    if (v < SIM_MIN) return SIM_MIN;
    return v;
  endfunction

  function automatic int active_count();
    if (clusters_reg == 0) return 1;
    if (clusters_reg > 16) return 16;
    return int'(clusters_reg);
  endfunction

  // advance the mirrored state by one item; returns 1 when a result is due
  function automatic bit assign_step(input item_s s, output skak_pkg::result_t r);
    int n;
    int idx;
    int best;
    longint bsim;
    n = active_count();
    idx = s.col * 16 + s.cl;
    r = '0;
    case (s.cmd)
      skak_pkg::CMD_LOAD: begin
        center_mem[idx] = s.val;
        return 1'b0;
      end
      skak_pkg::CMD_SIM: begin
        if (s.pres)
          for (int k = 0; k < n; k++)
            row_sim[k] = clamp40(row_sim[k] + longint'(s.val) *
                                 longint'(center_mem[s.col * 16 + k]));
        if (!s.last) return 1'b0;
        best = 0;
        bsim = row_sim[0];
        for (int k = 1; k < n; k++)
          if (row_sim[k] > bsim) begin
            bsim = row_sim[k];
            best = k;
          end
        r.kind = skak_pkg::KIND_ROW;
        r.best = 4'(best);
        r.moved = (s.prev < 0) || (int'(s.prev) != best);
        r.sim = bsim[39:0];
        for (int k = 0; k < 16; k++) row_sim[k] = 0;
        return 1'b1;
      end
      skak_pkg::CMD_ACC: begin
        if (s.pres && s.cl < n) sum_mem[idx] = clamp40(sum_mem[idx] + s.val);
        return 1'b0;
      end
      default: begin
        r.kind = skak_pkg::KIND_SUM;
        r.sum = sum_mem[idx][39:0];
        sum_mem[idx] = 0;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic item_s mk(skak_pkg::cmd_t c, int col, int cl, int val, int last,
                               int pres, int prev);
    item_s s;
    s.cmd = c; s.col = 12'(col); s.cl = 4'(cl); s.val = 16'(val);
    s.last = 1'(last); s.pres = 1'(pres); s.prev = 5'(prev);
    return s;
  endfunction

  function automatic skak_pkg::result_t row_res(int best, bit mv, longint sim);
    skak_pkg::result_t r;
    r = '0;
    r.kind = skak_pkg::KIND_ROW; r.best = 4'(best); r.moved = mv; r.sim = sim[39:0];
    return r;
  endfunction

  function automatic skak_pkg::result_t sum_res(longint sum);
    skak_pkg::result_t r;
    r = '0;
    r.kind = skak_pkg::KIND_SUM; r.sum = sum[39:0];
    return r;
  endfunction

  // present one item and wait for it to be taken
  task automatic send_item(input item_s s, input bit typed, input skak_pkg::result_t tr);
    int gap;
    skak_pkg::result_t r;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= s.cmd; column <= s.col; cluster <= s.cl; value <= s.val;
    last_of_row <= s.last; element_present <= s.pres; previous_cluster <= s.prev;
    do @(posedge clk); while (!in_ready);
    if (assign_step(s, r)) expected_q.push_back(typed ? tr : r);
  endtask

  task automatic send(input item_s s);
    send_item(s, 1'b0, '0);
  endtask

  // drain outstanding results, then write the register
  task automatic set_clusters(input logic [4:0] v);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    clusters_reg = v;
  endtask

  function automatic int pick_center_col();
    return center_cols[$urandom_range(center_cols.size() - 1)];
  endfunction

  // random item, mostly well-formed traffic on loaded columns
  function automatic item_s rand_item();
    int sel;
    int col;
    sel = $urandom_range(99);
    col = ($urandom_range(3) == 0) ? $urandom_range(4095) : pick_center_col();
    if (sel < 10)
      return mk(skak_pkg::CMD_LOAD, pick_center_col(), $urandom_range(15), $urandom,
                $urandom_range(1), $urandom_range(1), $urandom);
    if (sel < 55) begin
      if ($urandom_range(99) < 85)
        return mk(skak_pkg::CMD_SIM, pick_center_col(), $urandom_range(15), $urandom,
                  int'($urandom_range(3) == 0), 1, $urandom);
      return mk(skak_pkg::CMD_SIM, $urandom_range(4095), $urandom_range(15), $urandom,
                int'($urandom_range(3) == 0), 0, $urandom);
    end
    if (sel < 80)
      return mk(skak_pkg::CMD_ACC, col, $urandom_range(15), $urandom, $urandom_range(1),
                int'($urandom_range(9) != 0), $urandom);
    return mk(skak_pkg::CMD_READ, col, $urandom_range(15), $urandom, $urandom_range(1),
              $urandom_range(1), $urandom);
  endfunction

  row_s directed_tbl[];

  // result checker and receiver stalls
  always @(posedge clk) begin
    skak_pkg::result_t e;
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
      end else begin
        e = expected_q.pop_front();
        if (result_kind !== e.kind || best_cluster !== e.best || moved !== e.moved ||
            best_similarity !== e.sim || sum_value !== e.sum) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: exp kind %0d best %0d moved %0d sim %0d sum %0d",
                     $realtime, e.kind, e.best, e.moved, e.sim, e.sum);
            $display("  got kind %0d best %0d moved %0d sim %0d sum %0d",
                     result_kind, best_cluster, moved, best_similarity, sum_value);
          end
        end
      end
    end
  end

  initial begin
    #(12 * 1000000);
    $display("simulation failed");
    $finish;
  end

  initial begin
    for (int i = 0; i < 65536; i++) begin
      center_mem[i] = '0;
      sum_mem[i] = 0;
    end
    for (int k = 0; k < 16; k++) row_sim[k] = 0;
    clusters_reg = 5'd16;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 0: no idling, full cluster count
    send_idle_pct = 0; recv_stall_pct = 0;
    set_clusters(5'd16);
    center_cols = '{0, 4095, 12'hAAA, 12'h555};
    for (int i = 0; i < 4; i++) center_cols.push_back($urandom_range(1, 4094));
    foreach (center_cols[c])
      for (int k = 0; k < 16; k++)
        send(mk(skak_pkg::CMD_LOAD, center_cols[c], k,
                center_cols[c] == 0 ? 32767 : center_cols[c] == 4095 ? -32768 : $urandom,
                0, 1, 0));

    directed_tbl = '{
      // empty rows
      '{mk(skak_pkg::CMD_SIM, 0, 0, 0, 1, 0, -1), 1'b1, row_res(0, 1'b1, 0)},
      '{mk(skak_pkg::CMD_SIM, 4095, 15, -1, 1, 0, 0), 1'b1, row_res(0, 1'b0, 0)},
      // readouts of never-touched sums
      '{mk(skak_pkg::CMD_READ, 100, 5, 0, 0, 0, 0), 1'b1, sum_res(0)},
      '{mk(skak_pkg::CMD_READ, 4095, 15, 0, 0, 0, 0), 1'b1, sum_res(0)},
      // accumulate extremes on one column, then read and clear
      '{mk(skak_pkg::CMD_ACC, 7, 3, 32767, 0, 1, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_ACC, 7, 3, -32768, 1, 1, -1), 1'b0, '0},
      '{mk(skak_pkg::CMD_READ, 7, 3, 0, 0, 0, 0), 1'b1, sum_res(-1)},
      // accumulate without a nonzero adds nothing
      '{mk(skak_pkg::CMD_ACC, 7, 3, 100, 0, 0, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_READ, 7, 3, 0, 1, 1, 15), 1'b1, sum_res(0)},
      // all clusters tie: lowest index wins
      '{mk(skak_pkg::CMD_SIM, 0, 0, 32767, 0, 1, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_SIM, 0, 0, 32767, 1, 1, 0), 1'b1,
        row_res(0, 1'b0, 64'sd2147352578)},
      '{mk(skak_pkg::CMD_SIM, 4095, 0, -32768, 1, 1, 3), 1'b1,
        row_res(0, 1'b1, 64'sd1073741824)},
      // load with the row fields set, readout of that column
      '{mk(skak_pkg::CMD_LOAD, 12'h800, 9, 1234, 1, 0, 15), 1'b0, '0},
      '{mk(skak_pkg::CMD_READ, 12'h800, 9, 0, 1, 1, -16), 1'b1, sum_res(0)},
      // mixed rows and accumulates
      '{mk(skak_pkg::CMD_SIM, 12'hAAA, 2, 1000, 0, 1, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_SIM, 12'h555, 5, -5, 1, 1, 15), 1'b0, '0},
      '{mk(skak_pkg::CMD_ACC, 12'hAAA, 15, -32768, 0, 1, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_ACC, 12'hAAA, 15, -32768, 0, 1, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_READ, 12'hAAA, 15, 0, 0, 0, 0), 1'b0, '0},
      '{mk(skak_pkg::CMD_SIM, 12'h555, 0, 32767, 1, 1, 7), 1'b0, '0}
    };
    foreach (directed_tbl[i])
      send_item(directed_tbl[i].it, directed_tbl[i].typed, directed_tbl[i].res);
    repeat (60) send(rand_item());

    // phase 1: sender idle, one cluster, positive saturation
    send_idle_pct = 65; recv_stall_pct = 0;
    set_clusters(5'd1);
    send(mk(skak_pkg::CMD_LOAD, 4095, 0, -32768, 0, 1, 0));
    repeat (520) send(mk(skak_pkg::CMD_SIM, 4095, 0, -32768, 0, 1, 0));
    send(mk(skak_pkg::CMD_SIM, 4095, 0, -32768, 1, 1, 0));
    repeat (50) send(rand_item());

    // phase 2: receiver stalls, zero acts as one
    send_idle_pct = 0; recv_stall_pct = 65;
    set_clusters(5'd0);
    repeat (60) send(rand_item());

    // phase 3: both sides idle, oversized count, negative saturation
    send_idle_pct = 35; recv_stall_pct = 35;
    set_clusters(5'd31);
    send(mk(skak_pkg::CMD_LOAD, 4095, 0, -32768, 0, 1, 0));
    repeat (520) send(mk(skak_pkg::CMD_SIM, 4095, 0, 32767, 0, 1, 0));
    send(mk(skak_pkg::CMD_SIM, 4095, 0, 32767, 1, 1, -1));
    repeat (50) send(rand_item());

    // phase 4: random count, bursts alternating with idle stretches
    set_clusters(5'($urandom_range(2, 15)));
    for (int i = 0; i < 60; i++) begin
      send_idle_pct = (i % 20 < 10) ? 0 : 35;
      recv_stall_pct = (i % 16 < 8) ? 0 : 65;
      send(rand_item());
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
